FILE: src/sepb_pkg.sv
// Shared types, constants and microprogram of the smoothed equal-power balance unit.
package sepb_pkg;

    // Default sizes handed down from the top level
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int TRIG_DEPTH_DEF  = 256;

    // Fixed-point constants
    localparam int Q15_ONE   = 32768;
    localparam int ALPHA_ONE = 65536;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TARGET_PAN = 2'd0,
        REG_TARGET_STR = 2'd1,
        REG_ALPHA      = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [16:0] target_pan;
        logic [15:0]        target_strength;
        logic [16:0]        alpha;
    } t_cfg;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_PAN,
        MUL_STR,
        MUL_INTERP,
        MUL_BLEND,
        MUL_SCALE_L,
        MUL_SCALE_R
    } t_mul_sel;

    // Write-back of the previous product
    typedef enum logic [2:0] {
        WB_NONE,
        WB_PAN,
        WB_STR,
        WB_LAW,
        WB_GAIN_R,
        WB_GAIN_L,
        WB_RES_L
    } t_wb_sel;

    // Sine table read side
    typedef enum logic [1:0] {
        RD_NONE,
        RD_RIGHT,
        RD_LEFT
    } t_rd_sel;

    typedef enum logic {
        JMP_NONE,
        JMP_NO_BLOCK
    } t_jmp_sel;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_SCALE = 4'd8;

    typedef struct packed {
        t_mul_sel        mul;
        t_wb_sel         wb;
        t_rd_sel         rd;
        t_jmp_sel        jmp;
        logic [PC_W-1:0] target;
        logic            fin;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   adv;   // step executes this cycle
        logic   load;  // input request captured
    } t_dp_ctl;

    localparam t_uword UW_NOP = '{mul: MUL_NONE, wb: WB_NONE, rd: RD_NONE,
                                  jmp: JMP_NONE, target: '0, fin: 1'b0};

    // Microprogram: a step may launch one product and may write back the one before it
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            4'd0: begin
                w.mul    = MUL_PAN;
                w.jmp    = JMP_NO_BLOCK;
                w.target = STEP_SCALE;
            end
            4'd1: begin
                w.mul = MUL_STR;
                w.wb  = WB_PAN;
            end
            4'd2: begin
                w.wb = WB_STR;
                w.rd = RD_RIGHT;
            end
            4'd3: begin
                w.mul = MUL_INTERP;
                w.rd  = RD_LEFT;
            end
            4'd4: begin
                w.mul = MUL_INTERP;
                w.wb  = WB_LAW;
            end
            4'd5: begin
                w.mul = MUL_BLEND;
                w.wb  = WB_LAW;
            end
            4'd6: begin
                w.mul = MUL_BLEND;
                w.wb  = WB_GAIN_R;
            end
            4'd7: begin
                w.wb = WB_GAIN_L;
            end
            4'd8: begin
                w.mul = MUL_SCALE_L;
            end
            4'd9: begin
                w.mul = MUL_SCALE_R;
                w.wb  = WB_RES_L;
            end
            4'd10: begin
                w.fin = 1'b1;
            end
            default: w = UW_NOP;
        endcase
        return w;
    endfunction

endpackage

FILE: src/sepb_cfg.sv
// APB register bank holding the clamped target and smoothing registers.
module sepb_cfg
    import sepb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic signed [16:0] r_pan;
    logic [15:0]        r_str;
    logic [16:0]        r_alpha;
    logic signed [16:0] n_pan;
    logic [15:0]        n_str;
    logic [16:0]        n_alpha;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    // Clamp incoming values to their legal ranges
    always_comb begin
        n_pan = $signed(pwdata[16:0]);
        if (n_pan > 17'sd32768) begin
            n_pan = 17'sd32768;
        end else if (n_pan < -17'sd32768) begin
            n_pan = -17'sd32768;
        end
        n_str = (pwdata[15:0] > 16'(Q15_ONE)) ? 16'(Q15_ONE) : pwdata[15:0];
        n_alpha = (pwdata[16:0] > 17'(ALPHA_ONE)) ? 17'(ALPHA_ONE) : pwdata[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan   <= '0;
            r_str   <= 16'(Q15_ONE);
            r_alpha <= 17'(ALPHA_ONE);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TARGET_PAN: r_pan   <= n_pan;
                REG_TARGET_STR: r_str   <= n_str;
                REG_ALPHA:      r_alpha <= n_alpha;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_TARGET_PAN: prdata = 32'(r_pan);
            REG_TARGET_STR: prdata = 32'(r_str);
            REG_ALPHA:      prdata = 32'(r_alpha);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.target_pan      = r_pan;
    assign o_cfg.target_strength = r_str;
    assign o_cfg.alpha           = r_alpha;

endmodule

FILE: src/sepb_sine_rom.sv
// Quarter-wave sine table in Q1.15, two registered read ports.
module sepb_sine_rom
    import sepb_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF,
    localparam int AW = $clog2(TRIG_TABLE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_addr_a,
    input  logic [AW-1:0] i_addr_b,
    output logic [15:0]   o_data_a,
    output logic [15:0]   o_data_b
);

    logic [15:0] w_tab [0:TRIG_TABLE_DEPTH];

    // Entries come from a Taylor series in Q2.30, evaluated at elaboration
    for (genvar k = 0; k <= TRIG_TABLE_DEPTH; k++) begin : g_tab
        localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(k)) / TRIG_TABLE_DEPTH;
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X  * X2) >> 30) / 6;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 20;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 42;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 72;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 110;
        localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 156;
        localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 210;
        localparam logic signed [63:0] S = $signed(X) - $signed(T1) + $signed(T2)
                                         - $signed(T3) + $signed(T4) - $signed(T5)
                                         + $signed(T6) - $signed(T7);
        localparam logic signed [63:0] R = (S < 0) ? 64'sd0 : S;
        localparam logic signed [63:0] Q = (R + 64'sd16384) >>> 15;
        localparam logic signed [63:0] V = (Q > 64'sd32768) ? 64'sd32768 : Q;
        assign w_tab[k] = 16'(V);
    end

    always_ff @(posedge i_clk) begin
        o_data_a <= w_tab[i_addr_a];
        o_data_b <= w_tab[i_addr_b];
    end

endmodule

FILE: src/sepb_sequencer.sv
// Step counter and control store that drive the datapath.
module sepb_sequencer
    import sepb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_block_start,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_ctl o_ctl
);

    t_seq_state      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_blk, n_blk;
    logic            r_o_valid, n_o_valid;
    t_uword          w_uw;
    logic            w_adv;
    logic            w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SEQ_IDLE;
            r_pc      <= '0;
            r_blk     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_blk     <= n_blk;
            r_o_valid <= n_o_valid;
        end
    end

    // Next state, step sequencing and output valid
    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_blk     = r_blk;
        n_o_valid = r_o_valid;
        w_uw      = UW_NOP;
        w_adv     = 1'b0;
        w_load    = 1'b0;
        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_in_valid) begin
                    w_load  = 1'b1;
                    n_state = SEQ_RUN;
                    n_pc    = '0;
                    n_blk   = i_block_start;
                end
            end
            SEQ_RUN: begin
                w_uw = ucode(r_pc);
                // last step waits while the output register is still full
                w_adv = !(w_uw.fin && r_o_valid && !i_out_ready);
                if (w_adv) begin
                    if (w_uw.fin) begin
                        n_state   = SEQ_IDLE;
                        n_o_valid = 1'b1;
                    end else if (w_uw.jmp == JMP_NO_BLOCK && !r_blk) begin
                        n_pc = w_uw.target;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == SEQ_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_ctl.uw    = w_uw;
    assign o_ctl.adv   = w_adv;
    assign o_ctl.load  = w_load;

endmodule

FILE: src/sepb_datapath.sv
// Shared multiplier, rounding, clamping and state registers of the balance unit.
module sepb_datapath
    import sepb_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF,
    localparam int AW = $clog2(TRIG_TABLE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_ctl                       i_ctl,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_right,
    output logic [AW-1:0]                 o_rom_addr_a,
    output logic [AW-1:0]                 o_rom_addr_b,
    input  logic [15:0]                   i_rom_data_a,
    input  logic [15:0]                   i_rom_data_b,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right
);

    localparam int MW = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
    localparam int PW = MW + 18;
    localparam int SW = 17 + AW;
    localparam logic signed [PW-1:0] HALF16  = PW'(32768);
    localparam logic signed [PW-1:0] HALF15  = PW'(16384);
    localparam logic signed [PW-1:0] ONE_PW  = PW'(Q15_ONE);
    localparam logic signed [PW-1:0] SMP_MAX = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SMP_MIN = -SMP_MAX - PW'(1);
    localparam logic signed [MW-1:0] ONE_MW  = MW'(Q15_ONE);

    // State and working registers
    logic signed [SAMPLE_BITS-1:0] r_smp_l, r_smp_r, r_res_l;
    logic signed [16:0]            r_sp;
    logic [15:0]                   r_ss, r_gl, r_gr;
    logic [15:0]                   r_frac, r_base;
    logic signed [17:0]            r_law;
    logic signed [PW-1:0]          r_prod;

    logic signed [MW-1:0] w_ma;
    logic signed [17:0]   w_mb;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_rnd16, w_rnd15;
    logic signed [PW-1:0] w_pan_sum, w_str_sum, w_gain_sum;
    logic signed [16:0]   w_pan_new;
    logic [15:0]          w_str_new, w_gain_new;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic [16:0]          w_t, w_pos;
    logic [SW-1:0]        w_scaled;
    logic [AW-1:0]        w_idx;

    // Multiplier operand selection
    always_comb begin
        unique case (i_ctl.uw.mul)
            MUL_PAN: begin
                w_ma = MW'(i_cfg.target_pan) - MW'(r_sp);
                w_mb = $signed({1'b0, i_cfg.alpha});
            end
            MUL_STR: begin
                w_ma = MW'($signed({1'b0, i_cfg.target_strength})) - MW'($signed({1'b0, r_ss}));
                w_mb = $signed({1'b0, i_cfg.alpha});
            end
            MUL_INTERP: begin
                w_ma = MW'($signed({1'b0, i_rom_data_b})) - MW'($signed({1'b0, i_rom_data_a}));
                w_mb = $signed({2'b0, r_frac});
            end
            MUL_BLEND: begin
                w_ma = MW'(r_law) - ONE_MW;
                w_mb = $signed({2'b0, r_ss});
            end
            MUL_SCALE_L: begin
                w_ma = MW'(r_smp_l);
                w_mb = $signed({2'b0, r_gl});
            end
            MUL_SCALE_R: begin
                w_ma = MW'(r_smp_r);
                w_mb = $signed({2'b0, r_gr});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // Round half up of the held product
    assign w_rnd16 = (r_prod + HALF16) >>> 16;
    assign w_rnd15 = (r_prod + HALF15) >>> 15;

    // Smoothed pan and strength updates, gain sums and sample saturation, clamped
    assign w_pan_sum  = PW'(r_sp) + w_rnd16;
    assign w_str_sum  = PW'($signed({1'b0, r_ss})) + w_rnd16;
    assign w_gain_sum = ONE_PW + w_rnd15;

    always_comb begin
        if (w_pan_sum > PW'(Q15_ONE)) begin
            w_pan_new = 17'sd32768;
        end else if (w_pan_sum < -PW'(Q15_ONE)) begin
            w_pan_new = -17'sd32768;
        end else begin
            w_pan_new = 17'(w_pan_sum);
        end
        if (w_str_sum > PW'(Q15_ONE)) begin
            w_str_new = 16'(Q15_ONE);
        end else if (w_str_sum < 0) begin
            w_str_new = '0;
        end else begin
            w_str_new = 16'(w_str_sum);
        end
        if (w_gain_sum > PW'(Q15_ONE)) begin
            w_gain_new = 16'(Q15_ONE);
        end else if (w_gain_sum < 0) begin
            w_gain_new = '0;
        end else begin
            w_gain_new = 16'(w_gain_sum);
        end
        if (w_rnd15 > SMP_MAX) begin
            w_sat = SAMPLE_BITS'(SMP_MAX);
        end else if (w_rnd15 < SMP_MIN) begin
            w_sat = SAMPLE_BITS'(SMP_MIN);
        end else begin
            w_sat = SAMPLE_BITS'(w_rnd15);
        end
    end

    // Table position: right gain reads at pan + 1, left gain at the mirror
    assign w_t      = 17'(18'(r_sp) + 18'sd32768);
    assign w_pos    = (i_ctl.uw.rd == RD_LEFT) ? (17'(ALPHA_ONE) - w_t) : w_t;
    assign w_scaled = SW'(w_pos) * SW'(TRIG_TABLE_DEPTH);
    assign w_idx    = w_scaled[15+AW:16];

    assign o_rom_addr_a = w_idx;
    assign o_rom_addr_b = (w_idx == AW'(TRIG_TABLE_DEPTH)) ? w_idx : w_idx + 1'b1;

    // Smoothing and gain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_ss <= 16'(Q15_ONE);
            r_gl <= 16'(Q15_ONE);
            r_gr <= 16'(Q15_ONE);
        end else if (i_ctl.adv) begin
            unique case (i_ctl.uw.wb)
                WB_PAN:    r_sp <= w_pan_new;
                WB_STR:    r_ss <= w_str_new;
                WB_GAIN_R: r_gr <= w_gain_new;
                WB_GAIN_L: r_gl <= w_gain_new;
                default: ;
            endcase
        end
    end

    // Working registers and output data
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_smp_l <= i_sample_left;
            r_smp_r <= i_sample_right;
        end
        if (i_ctl.adv) begin
            if (i_ctl.uw.mul != MUL_NONE) begin
                r_prod <= w_prod;
            end
            if (i_ctl.uw.rd != RD_NONE) begin
                r_frac <= w_scaled[15:0];
            end
            if (i_ctl.uw.mul == MUL_INTERP) begin
                r_base <= i_rom_data_a;
            end
            if (i_ctl.uw.wb == WB_LAW) begin
                r_law <= 18'(PW'($signed({1'b0, r_base})) + w_rnd16);
            end
            if (i_ctl.uw.wb == WB_RES_L) begin
                r_res_l <= w_sat;
            end
            if (i_ctl.uw.fin) begin
                o_out_left  <= r_res_l;
                o_out_right <= w_sat;
            end
        end
    end

endmodule

FILE: src/smoothed_equal_power_balance_unit.sv
// Top level of the smoothed equal-power stereo balance unit.
//
//  channel   | direction | handshake               | contents
//  ----------+-----------+-------------------------+------------------------------------
//  s_axis    | in        | tvalid / tready         | tdata: sample_left, sample_right;
//            |           |                         | tuser: block_start
//  m_axis    | out       | tvalid / tready         | tdata: out_left, out_right
//  apb       | in/out    | psel, penable, pready   | target_pan, target_strength, alpha
//
// A frame without block_start jumps from the first step to the scaling steps; a frame with
// block_start runs every step, the microprogram stepping through the single shared multiplier.
// The output register holds one finished frame, so the next request is taken while
// it waits; a full output register holds the last program step.
// Reset is synchronous, active low; it restores the register defaults, centre pan,
// full strength and unity gains. No clearing pass is needed.
module smoothed_equal_power_balance_unit
    import sepb_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF,
    localparam int TD_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int AW   = $clog2(TRIG_TABLE_DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // configuration
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    // input frames
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [TD_W-1:0] i_s_axis_tdata,   // sample_left, sample_right
    input  logic [0:0]      i_s_axis_tuser,   // block_start
    // output frames
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [TD_W-1:0] o_m_axis_tdata    // out_left, out_right, zero fill
);

    t_cfg                          w_cfg;
    t_dp_ctl                       w_ctl;
    logic [AW-1:0]                 w_addr_a, w_addr_b;
    logic [15:0]                   w_rom_a, w_rom_b;
    logic signed [SAMPLE_BITS-1:0] w_out_l, w_out_r;

    sepb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sepb_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .i_block_start (i_s_axis_tuser[0]),
        .o_in_ready    (o_s_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_ctl         (w_ctl)
    );

    sepb_sine_rom #(
        .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
    ) u_rom (
        .i_clk    (i_clk),
        .i_addr_a (w_addr_a),
        .i_addr_b (w_addr_b),
        .o_data_a (w_rom_a),
        .o_data_b (w_rom_b)
    );

    sepb_datapath #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_cfg          (w_cfg),
        .i_sample_left  ($signed(i_s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_sample_right ($signed(i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .o_rom_addr_a   (w_addr_a),
        .o_rom_addr_b   (w_addr_b),
        .i_rom_data_a   (w_rom_a),
        .i_rom_data_b   (w_rom_b),
        .o_out_left     (w_out_l),
        .o_out_right    (w_out_r)
    );

    assign o_m_axis_tdata = TD_W'({w_out_r, w_out_l});

    // A taken request keeps the input closed while the program runs
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready while a frame is in progress");

    // A new result only appears from a running program
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result produced without a frame in progress");

    // Register clamps keep the smoothing inputs in range
    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg.alpha <= 17'(ALPHA_ONE)) && (w_cfg.target_strength <= 16'(Q15_ONE)))
        else $error("configuration register out of range");

endmodule
